@@ design/lcks_pkg.sv @@
// shared types and constants for the load-cell averaging kalman scale
// no dependencies
package lcks_pkg;

    localparam int RING_DEPTH = 16;
    localparam int RING_IDX_W = $clog2(RING_DEPTH);
    localparam int LEN_W      = RING_IDX_W + 1;
    localparam int SAMPLE_W   = 24;
    localparam int SUM_W      = SAMPLE_W + RING_IDX_W;
    localparam int AVG_W      = 25;
    localparam int EST_W      = 48;
    localparam int VAR_W      = 32;
    localparam int GAIN_W     = 16;
    localparam int SCALE_W    = 48;
    localparam int WEIGHT_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // divider geometry, shared by the average and the gain
    localparam int DIV_N_W    = 48;
    localparam int DIV_D_W    = 33;
    localparam int DIV_CNT_W  = 6;

    localparam logic [LEN_W-1:0]   RST_WINDOW_LEN = LEN_W'(3);
    localparam logic [SCALE_W-1:0] RST_GRAMS      = SCALE_W'(3217446);
    localparam logic [VAR_W-1:0]   RST_NOISE      = VAR_W'(655360);
    localparam logic [VAR_W-1:0]   RST_VARIANCE   = VAR_W'(983040);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LEN      = 3'd0,
        CFG_TARE_OFFSET     = 3'd1,
        CFG_GRAMS_PER_COUNT = 3'd2,
        CFG_PROCESS_NOISE   = 3'd3,
        CFG_MEASURE_NOISE   = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRAP,
        S_SUM,
        S_AVG_START,
        S_AVG_WAIT,
        S_GAIN_START,
        S_GAIN_WAIT,
        S_MUL,
        S_APPLY,
        S_WEIGHT,
        S_OUT
    } t_state;

endpackage

@@ design/lcks_div.sv @@
// restoring unsigned divider, one quotient bit per cycle
// uses lcks_pkg
module lcks_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [lcks_pkg::DIV_N_W-1:0]   i_dividend,
    input  logic [lcks_pkg::DIV_D_W-1:0]   i_divisor,
    output logic                           o_done,
    output logic [lcks_pkg::DIV_N_W-1:0]   o_quotient
);
    logic                            r_busy, n_busy;
    logic                            r_done, n_done;
    logic [lcks_pkg::DIV_CNT_W-1:0]  r_cnt, n_cnt;
    logic [lcks_pkg::DIV_D_W-1:0]    r_rem, n_rem;
    logic [lcks_pkg::DIV_N_W-1:0]    r_quo, n_quo;
    logic [lcks_pkg::DIV_D_W-1:0]    r_div, n_div;
    logic [lcks_pkg::DIV_D_W:0]      w_trial;

    assign w_trial = {r_rem, r_quo[lcks_pkg::DIV_N_W-1]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_cnt  = '0;
                n_rem  = '0;
                n_quo  = i_dividend;
                n_div  = i_divisor;
            end
        end else begin
            // shift in next dividend bit, subtract when it fits
            if (w_trial >= {1'b0, r_div}) begin
                n_rem = lcks_pkg::DIV_D_W'(w_trial - {1'b0, r_div});
                n_quo = {r_quo[lcks_pkg::DIV_N_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[lcks_pkg::DIV_D_W-1:0];
                n_quo = {r_quo[lcks_pkg::DIV_N_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == lcks_pkg::DIV_CNT_W'(lcks_pkg::DIV_N_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

@@ design/load_cell_average_kalman_scale.sv @@
// load-cell moving average with scalar kalman filter and scaling to grams
// uses lcks_pkg and lcks_div
// sequence: index wrap, window sum, average division, gain division, update, then weight
//   product; the shared 48-step divider is used twice and the 32x32 multiplier four times;
//   the gain division is skipped when variance plus noise is zero, and the index wrap
//   runs longer right after the window shrinks
// throughput: one request at a time
// the result register lets the next request enter while a result waits
// reset (synchronous, active low): ring zeroed, write index and estimate zero,
//   variance 15.0, registers to defaults
module load_cell_average_kalman_scale (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [lcks_pkg::SAMPLE_W-1:0]   i_raw_sample,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [lcks_pkg::AVG_W-1:0]      o_averaged_value,
    output logic signed [lcks_pkg::WEIGHT_W-1:0]   o_weight_grams,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [lcks_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [lcks_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    // configuration registers
    logic [lcks_pkg::LEN_W-1:0]            r_win;
    logic signed [lcks_pkg::SAMPLE_W-1:0]  r_tare;
    logic [lcks_pkg::SCALE_W-1:0]          r_gpc;
    logic [lcks_pkg::VAR_W-1:0]            r_q;
    logic [lcks_pkg::VAR_W-1:0]            r_r;

    // filter state
    lcks_pkg::t_state                      r_state, n_state;
    logic signed [lcks_pkg::SAMPLE_W-1:0]  r_ring [lcks_pkg::RING_DEPTH];
    logic [lcks_pkg::RING_IDX_W-1:0]       r_widx, n_widx;
    logic signed [lcks_pkg::EST_W-1:0]     r_est, n_est;
    logic [lcks_pkg::VAR_W-1:0]            r_p, n_p;

    // working registers
    logic [lcks_pkg::LEN_W-1:0]            r_wrap, n_wrap;
    logic [lcks_pkg::LEN_W-1:0]            r_cnt, n_cnt;
    logic signed [lcks_pkg::SUM_W-1:0]     r_sum, n_sum;
    logic signed [lcks_pkg::AVG_W-1:0]     r_u, n_u;
    logic [lcks_pkg::GAIN_W-1:0]           r_gain, n_gain;
    logic signed [65:0]                    r_prod_e, n_prod_e;
    logic [48:0]                           r_prod_p, n_prod_p;
    logic                                  r_neg, n_neg;
    logic [lcks_pkg::EST_W-1:0]            r_mag, n_mag;
    logic [63:0]                           r_pp, n_pp;
    logic [1:0]                            r_psh, n_psh;
    logic [95:0]                           r_acc, n_acc;

    // result register
    logic                                  r_ovalid, n_ovalid;
    logic signed [lcks_pkg::AVG_W-1:0]     r_oavg, n_oavg;
    logic signed [lcks_pkg::WEIGHT_W-1:0]  r_owt, n_owt;

    logic                                  w_ring_we;
    logic [lcks_pkg::LEN_W-1:0]            w_len;
    logic                                  w_accept;
    logic                                  w_out_free;

    // shared divider
    logic                                  w_div_start;
    logic                                  w_div_done;
    logic [lcks_pkg::DIV_N_W-1:0]          w_div_n;
    logic [lcks_pkg::DIV_D_W-1:0]          w_div_d;
    logic [lcks_pkg::DIV_N_W-1:0]          w_div_q;

    // combinational helpers
    logic [lcks_pkg::SUM_W-1:0]            w_sum_mag;
    logic signed [lcks_pkg::AVG_W-1:0]     w_avg;
    logic [lcks_pkg::DIV_D_W-1:0]          w_den;
    logic signed [48:0]                    w_diff;
    logic signed [65:0]                    w_bias;
    logic signed [65:0]                    w_prod_rnd;
    logic signed [49:0]                    w_est_sum;
    logic signed [lcks_pkg::EST_W-1:0]     w_est_sat;
    logic [33:0]                           w_p_sum;
    logic [31:0]                           w_ma, w_mb;
    logic [95:0]                           w_pp_sh;
    logic [lcks_pkg::EST_W-1:0]            w_wq;
    logic signed [lcks_pkg::WEIGHT_W-1:0]  w_weight;

    lcks_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_n),
        .i_divisor  (w_div_d),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    // effective window: zero acts as one, clamp at ring depth
    always_comb begin
        if (r_win == '0) begin
            w_len = lcks_pkg::LEN_W'(1);
        end else if (r_win > lcks_pkg::LEN_W'(lcks_pkg::RING_DEPTH)) begin
            w_len = lcks_pkg::LEN_W'(lcks_pkg::RING_DEPTH);
        end else begin
            w_len = r_win;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != lcks_pkg::S_IDLE);
    assign w_accept    = i_valid && !o_stall;
    assign w_out_free  = !r_ovalid || !i_stall;

    // configuration writes, taken any time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= lcks_pkg::RST_WINDOW_LEN;
            r_tare <= '0;
            r_gpc  <= lcks_pkg::RST_GRAMS;
            r_q    <= lcks_pkg::RST_NOISE;
            r_r    <= lcks_pkg::RST_NOISE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (lcks_pkg::t_cfg_idx'(i_cfg_index))
                lcks_pkg::CFG_WINDOW_LEN:
                    r_win  <= i_cfg_data[lcks_pkg::LEN_W-1:0];
                lcks_pkg::CFG_TARE_OFFSET:
                    r_tare <= $signed(i_cfg_data[lcks_pkg::SAMPLE_W-1:0]);
                lcks_pkg::CFG_GRAMS_PER_COUNT:
                    r_gpc  <= i_cfg_data[lcks_pkg::SCALE_W-1:0];
                lcks_pkg::CFG_PROCESS_NOISE:
                    r_q    <= i_cfg_data[lcks_pkg::VAR_W-1:0];
                lcks_pkg::CFG_MEASURE_NOISE:
                    r_r    <= i_cfg_data[lcks_pkg::VAR_W-1:0];
                default: ;
            endcase
        end
    end

    // datapath helpers
    always_comb begin
        // magnitude of the window sum for the unsigned divider
        w_sum_mag = r_sum[lcks_pkg::SUM_W-1] ? lcks_pkg::SUM_W'(-r_sum)
                                             : lcks_pkg::SUM_W'(r_sum);
        w_avg = r_sum[lcks_pkg::SUM_W-1] ? -$signed(w_div_q[lcks_pkg::AVG_W-1:0])
                                         : $signed(w_div_q[lcks_pkg::AVG_W-1:0]);
        w_den = {1'b0, r_p} + {1'b0, r_r};

        // innovation in q.16
        w_diff = $signed({r_u, 16'b0}) - $signed({r_est[lcks_pkg::EST_W-1], r_est});

        // gain * diff / 65536, truncated toward zero
        w_bias     = r_prod_e[65] ? 66'sd65535 : 66'sd0;
        w_prod_rnd = r_prod_e + w_bias;
        w_est_sum  = $signed({{2{r_est[lcks_pkg::EST_W-1]}}, r_est})
                   + $signed(w_prod_rnd[65:16]);
        if (w_est_sum[49:47] == 3'b000 || w_est_sum[49:47] == 3'b111) begin
            w_est_sat = w_est_sum[lcks_pkg::EST_W-1:0];
        end else if (w_est_sum[49]) begin
            w_est_sat = {1'b1, {(lcks_pkg::EST_W-1){1'b0}}};
        end else begin
            w_est_sat = {1'b0, {(lcks_pkg::EST_W-1){1'b1}}};
        end

        // next variance, saturating
        w_p_sum = {1'b0, r_prod_p[48:16]} + {2'b0, r_q};

        // weight partial products: step bit 0 picks estimate half, bit 1 scale half
        w_ma = r_cnt[0] ? {16'b0, r_mag[47:32]} : r_mag[31:0];
        w_mb = r_cnt[1] ? {16'b0, r_gpc[47:32]} : r_gpc[31:0];
        case (r_psh)
            2'd0:    w_pp_sh = {32'b0, r_pp};
            2'd1:    w_pp_sh = {r_pp, 32'b0};
            default: w_pp_sh = {r_pp[31:0], 64'b0};
        endcase

        // product / 2^48, then sign and int32 saturation
        w_wq = r_acc[95:48];
        if (r_neg) begin
            if (w_wq >= lcks_pkg::EST_W'(32'h8000_0000)) begin
                w_weight = {1'b1, 31'b0};
            end else begin
                w_weight = -$signed(w_wq[31:0]);
            end
        end else if (w_wq > lcks_pkg::EST_W'(32'h7FFF_FFFF)) begin
            w_weight = {1'b0, {31{1'b1}}};
        end else begin
            w_weight = $signed(w_wq[31:0]);
        end
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_widx   = r_widx;
        n_est    = r_est;
        n_p      = r_p;
        n_wrap   = r_wrap;
        n_cnt    = r_cnt;
        n_sum    = r_sum;
        n_u      = r_u;
        n_gain   = r_gain;
        n_prod_e = r_prod_e;
        n_prod_p = r_prod_p;
        n_neg    = r_neg;
        n_mag    = r_mag;
        n_pp     = r_pp;
        n_psh    = r_psh;
        n_acc    = r_acc;
        n_ovalid = r_ovalid && i_stall;
        n_oavg   = r_oavg;
        n_owt    = r_owt;
        w_ring_we   = 1'b0;
        w_div_start = 1'b0;
        w_div_n     = {{(lcks_pkg::DIV_N_W-lcks_pkg::SUM_W){1'b0}}, w_sum_mag};
        w_div_d     = {{(lcks_pkg::DIV_D_W-lcks_pkg::LEN_W){1'b0}}, w_len};

        unique case (r_state)
            lcks_pkg::S_IDLE: begin
                if (w_accept) begin
                    w_ring_we = 1'b1;
                    n_wrap    = {1'b0, r_widx} + 1'b1;
                    n_state   = lcks_pkg::S_WRAP;
                end
            end
            lcks_pkg::S_WRAP: begin
                // index modulo window, by repeated subtraction
                if (r_wrap >= w_len) begin
                    n_wrap = r_wrap - w_len;
                end else begin
                    n_widx  = r_wrap[lcks_pkg::RING_IDX_W-1:0];
                    n_cnt   = '0;
                    n_sum   = '0;
                    n_state = lcks_pkg::S_SUM;
                end
            end
            lcks_pkg::S_SUM: begin
                n_sum = r_sum + lcks_pkg::SUM_W'(r_ring[r_cnt[lcks_pkg::RING_IDX_W-1:0]]);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == w_len - 1'b1) begin
                    n_state = lcks_pkg::S_AVG_START;
                end
            end
            lcks_pkg::S_AVG_START: begin
                w_div_start = 1'b1;
                n_state     = lcks_pkg::S_AVG_WAIT;
            end
            lcks_pkg::S_AVG_WAIT: begin
                if (w_div_done) begin
                    n_u     = w_avg - lcks_pkg::AVG_W'(r_tare);
                    n_state = lcks_pkg::S_GAIN_START;
                end
            end
            lcks_pkg::S_GAIN_START: begin
                w_div_n = {r_p, 16'b0};
                w_div_d = w_den;
                if (w_den == '0) begin
                    n_gain  = '0;
                    n_state = lcks_pkg::S_MUL;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = lcks_pkg::S_GAIN_WAIT;
                end
            end
            lcks_pkg::S_GAIN_WAIT: begin
                if (w_div_done) begin
                    // full gain saturates just below one
                    n_gain = (w_div_q > lcks_pkg::DIV_N_W'(16'hFFFF))
                           ? 16'hFFFF : w_div_q[lcks_pkg::GAIN_W-1:0];
                    n_state = lcks_pkg::S_MUL;
                end
            end
            lcks_pkg::S_MUL: begin
                n_prod_e = $signed({1'b0, r_gain}) * w_diff;
                n_prod_p = (17'h10000 - {1'b0, r_gain}) * r_p;
                n_state  = lcks_pkg::S_APPLY;
            end
            lcks_pkg::S_APPLY: begin
                n_est = w_est_sat;
                n_p   = (w_p_sum > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : w_p_sum[31:0];
                n_neg = w_est_sat[lcks_pkg::EST_W-1];
                n_mag = w_est_sat[lcks_pkg::EST_W-1] ? lcks_pkg::EST_W'(-w_est_sat)
                                                     : lcks_pkg::EST_W'(w_est_sat);
                n_acc   = '0;
                n_cnt   = '0;
                n_state = lcks_pkg::S_WEIGHT;
            end
            lcks_pkg::S_WEIGHT: begin
                // multiply step k while step k-1 is accumulated
                if (r_cnt != '0) begin
                    n_acc = r_acc + w_pp_sh;
                end
                if (r_cnt[2]) begin
                    n_state = lcks_pkg::S_OUT;
                end else begin
                    n_pp  = w_ma * w_mb;
                    n_psh = 2'(r_cnt[0]) + 2'(r_cnt[1]);
                    n_cnt = r_cnt + 1'b1;
                end
            end
            lcks_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_oavg   = r_u;
                    n_owt    = w_weight;
                    n_state  = lcks_pkg::S_IDLE;
                end
            end
            default: n_state = lcks_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lcks_pkg::S_IDLE;
            r_widx   <= '0;
            r_est    <= '0;
            r_p      <= lcks_pkg::RST_VARIANCE;
            r_ovalid <= 1'b0;
            for (int k = 0; k < lcks_pkg::RING_DEPTH; k++) begin
                r_ring[k] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_widx   <= n_widx;
            r_est    <= n_est;
            r_p      <= n_p;
            r_ovalid <= n_ovalid;
            if (w_ring_we) begin
                r_ring[r_widx] <= i_raw_sample;
            end
        end
        r_wrap   <= n_wrap;
        r_cnt    <= n_cnt;
        r_sum    <= n_sum;
        r_u      <= n_u;
        r_gain   <= n_gain;
        r_prod_e <= n_prod_e;
        r_prod_p <= n_prod_p;
        r_neg    <= n_neg;
        r_mag    <= n_mag;
        r_pp     <= n_pp;
        r_psh    <= n_psh;
        r_acc    <= n_acc;
        r_oavg   <= n_oavg;
        r_owt    <= n_owt;
    end

    assign o_valid          = r_ovalid;
    assign o_averaged_value = r_oavg;
    assign o_weight_grams   = r_owt;
endmodule

@@ design/lcks_checker.sv @@
// port-level checks for the load-cell kalman scale
// bound to load_cell_average_kalman_scale, uses lcks_pkg widths
module lcks_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic                                   o_stall,
    input  logic signed [lcks_pkg::SAMPLE_W-1:0]   i_raw_sample,
    input  logic                                   o_valid,
    input  logic                                   i_stall,
    input  logic signed [lcks_pkg::AVG_W-1:0]      o_averaged_value,
    input  logic signed [lcks_pkg::WEIGHT_W-1:0]   o_weight_grams,
    input  logic                                   i_cfg_valid,
    input  logic                                   o_cfg_ready,
    input  logic [lcks_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [lcks_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    // a result held under stall stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // an accepted request keeps the block busy next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request accepted twice in a row");

    // a new result appears only as the sequencer returns to idle
    a_result_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !o_stall)
        else $error("result posted while still busy");

    // reset leaves no result pending
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
endmodule

bind load_cell_average_kalman_scale lcks_checker u_lcks_checker (.*);

@@ bench/tb_load_cell_average_kalman_scale.sv @@
// testbench for load_cell_average_kalman_scale: random and directed load-cell samples
// are driven through the request port and the results are checked against a predictor
// depends on lcks_pkg and the design files
`timescale 1ns / 1ps

module tb_load_cell_average_kalman_scale;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_valid;
    logic                                 o_stall;
    logic signed [lcks_pkg::SAMPLE_W-1:0] i_raw_sample;
    logic                                 o_valid;
    logic                                 i_stall;
    logic signed [lcks_pkg::AVG_W-1:0]    o_averaged_value;
    logic signed [lcks_pkg::WEIGHT_W-1:0] o_weight_grams;
    logic                                 i_cfg_valid;
    logic                                 o_cfg_ready;
    logic [lcks_pkg::CFG_IDX_W-1:0]       i_cfg_index;
    logic [lcks_pkg::CFG_DATA_W-1:0]      i_cfg_data;

    load_cell_average_kalman_scale i_dut (.*);

    // clock, 4 ns period
    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // scale settings mirrored by the predictor
    logic [4:0]              win_reg;
    logic signed [23:0]      tare_reg;
    logic [47:0]             grams_reg;
    logic [31:0]             q_reg;
    logic [31:0]             r_reg;
    // filter state mirrored by the predictor
    logic signed [23:0]      ring_m [lcks_pkg::RING_DEPTH];
    int unsigned             widx_m;
    logic signed [63:0]      est_m;
    logic [31:0]             var_m;

    typedef struct {
        logic signed [lcks_pkg::AVG_W-1:0]    avg;
        logic signed [lcks_pkg::WEIGHT_W-1:0] grams;
    } t_weighing;

    logic signed [lcks_pkg::SAMPLE_W-1:0] sample_q [$];
    t_weighing                            weighing_q [$];

    int errors;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_recv;
    int hold_cnt;
    int quiet_cycles;
    bit timed_out;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    // estimate times scale over 2^48, truncated toward zero, clamped to int32
    function automatic logic signed [31:0] grams_of(input logic signed [63:0] e,
                                                    input logic [47:0] s);
        logic [63:0]  mag;
        logic [127:0] prod;
        logic [127:0] quo;
        mag  = e < 0 ? 64'(-e) : 64'(e);
        prod = 128'(mag) * 128'(s);
        quo  = prod >> 48;
        if (e < 0) return quo >= 128'h8000_0000 ? 32'sh8000_0000 : -32'(quo);
        return quo > 128'h7FFF_FFFF ? 32'sh7FFF_FFFF : 32'(quo);
    endfunction

    // one sample through the moving average and kalman update
    function automatic t_weighing weigh_sample(input logic signed [23:0] smp);
        int unsigned        len;
        logic signed [63:0] sum;
        logic signed [63:0] u;
        logic signed [63:0] diff;
        logic signed [63:0] nxt;
        logic [63:0]        den;
        logic [63:0]        g;
        logic [63:0]        pv;
        logic signed [127:0] prod;
        t_weighing          res;
        len = win_reg == 0 ? 1 : (win_reg > lcks_pkg::RING_DEPTH ? lcks_pkg::RING_DEPTH
                                                                 : win_reg);
        ring_m[widx_m % lcks_pkg::RING_DEPTH] = smp;
        widx_m = ((widx_m % lcks_pkg::RING_DEPTH) + 1) % len;
        sum = 0;
        for (int k = 0; k < len; k++) sum += ring_m[k];
        u = sum / $signed(64'(len)) - tare_reg;
        den = 64'(var_m) + 64'(r_reg);
        if (den == 0) g = 0;
        else begin
            g = (64'(var_m) << 16) / den;
            if (g > 65535) g = 65535;
        end
        diff = u * 65536 - est_m;
        prod = $signed(128'(g)) * 128'(diff);
        nxt = est_m + 64'(prod / 65536);
        if (nxt > 64'sh7FFF_FFFF_FFFF) nxt = 64'sh7FFF_FFFF_FFFF;
        if (nxt < -64'sh8000_0000_0000) nxt = -64'sh8000_0000_0000;
        est_m = nxt;
        pv = ((64'd65536 - g) * 64'(var_m)) >> 16;
        pv += 64'(q_reg);
        var_m = pv > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : 32'(pv);
        res.avg   = lcks_pkg::AVG_W'(u);
        res.grams = grams_of(est_m, grams_reg);
        return res;
    endfunction

    // request driver, fed from sample_q
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_valid      <= 1'b1;
                i_raw_sample <= sample_q[0];
                weighing_q.push_back(weigh_sample(sample_q.pop_front()));
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with an optional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall  <= 1'b0;
            hold_cnt <= 0;
        end else if (hold_recv && hold_cnt < 2000) begin
            i_stall  <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end else begin
            i_stall <= $urandom_range(99) < recv_idle_pct;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (weighing_q.size() == 0) begin
                report_mismatch("unexpected result", 64'(o_averaged_value), 0);
            end else begin
                if (o_averaged_value !== weighing_q[0].avg)
                    report_mismatch("averaged_value", 64'(o_averaged_value),
                                    64'(weighing_q[0].avg));
                if (o_weight_grams !== weighing_q[0].grams)
                    report_mismatch("weight_grams", 64'(o_weight_grams),
                                    64'(weighing_q[0].grams));
                void'(weighing_q.pop_front());
            end
        end
    end

    // watchdog on cycles with no accepted request, result or configuration write
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) timed_out <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (timed_out) begin
            $display("tb_load_cell_average_kalman_scale NOT OK");
            $finish;
        end
    end

    task automatic write_reg(input lcks_pkg::t_cfg_idx idx, input logic [47:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            lcks_pkg::CFG_WINDOW_LEN:      win_reg   = val[4:0];
            lcks_pkg::CFG_TARE_OFFSET:     tare_reg  = val[23:0];
            lcks_pkg::CFG_GRAMS_PER_COUNT: grams_reg = val;
            lcks_pkg::CFG_PROCESS_NOISE:   q_reg     = val[31:0];
            lcks_pkg::CFG_MEASURE_NOISE:   r_reg     = val[31:0];
            default: ;
        endcase
    endtask

    // wait for every request to drain, then let the block settle
    task automatic drain;
        while (sample_q.size() > 0 || weighing_q.size() > 0 || i_valid) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // mostly small loads near a baseline, some full-range noise
    function automatic logic signed [23:0] rand_sample;
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? 24'sh7FFFFF : -24'sh800000;
            1, 2:    return 24'($urandom);
            default: return 24'sd100000 + 24'($signed($urandom_range(4000)) - 2000);
        endcase
    endfunction

    task automatic push_random(input int n);
        repeat (n) sample_q.push_back(rand_sample());
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_raw_sample  = '0;
        i_stall       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = lcks_pkg::CFG_WINDOW_LEN;
        i_cfg_data    = '0;
        errors        = 0;
        send_idle_pct = 8;
        recv_idle_pct = 61;
        hold_recv     = 1'b0;
        quiet_cycles  = 0;
        timed_out     = 1'b0;
        win_reg   = lcks_pkg::RST_WINDOW_LEN;
        tare_reg  = '0;
        grams_reg = lcks_pkg::RST_GRAMS;
        q_reg     = lcks_pkg::RST_NOISE;
        r_reg     = lcks_pkg::RST_NOISE;
        for (int k = 0; k < lcks_pkg::RING_DEPTH; k++) ring_m[k] = '0;
        widx_m = 0;
        est_m  = 0;
        var_m  = lcks_pkg::RST_VARIANCE;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes at reset settings, early averages hold zeros
        sample_q.push_back(24'sh7FFFFF);
        sample_q.push_back(-24'sh800000);
        sample_q.push_back(24'sd0);
        sample_q.push_back(-24'sd1);
        sample_q.push_back(24'sd1);
        sample_q.push_back(24'sh555555);
        sample_q.push_back(24'shAAAAAA);
        drain();

        // window zero acts as one, window too large clamps, zero denominator
        write_reg(lcks_pkg::CFG_WINDOW_LEN, 48'd0);
        write_reg(lcks_pkg::CFG_PROCESS_NOISE, 48'd0);
        write_reg(lcks_pkg::CFG_MEASURE_NOISE, 48'd0);
        sample_q.push_back(24'sd5000);
        sample_q.push_back(-24'sd7);
        drain();
        write_reg(lcks_pkg::CFG_WINDOW_LEN, 48'd31);
        write_reg(lcks_pkg::CFG_TARE_OFFSET, 48'h80_0000);
        write_reg(lcks_pkg::CFG_GRAMS_PER_COUNT, 48'hFFFF_FFFF_FFFF);
        write_reg(lcks_pkg::CFG_PROCESS_NOISE, 48'hFFFF_FFFF);
        for (int k = 0; k < 6; k++) sample_q.push_back(k[0] ? 24'sh7FFFFF : -24'sh800000);
        drain();
        // full gain with zero measurement noise, weight overflow both ways
        write_reg(lcks_pkg::CFG_WINDOW_LEN, 48'd16);
        write_reg(lcks_pkg::CFG_TARE_OFFSET, 48'h7F_FFFF);
        write_reg(lcks_pkg::CFG_MEASURE_NOISE, 48'd0);
        write_reg(lcks_pkg::CFG_PROCESS_NOISE, 48'd65536);
        for (int k = 0; k < 4; k++) sample_q.push_back(-24'sh800000);
        drain();
        // window changed mid-ring
        write_reg(lcks_pkg::CFG_WINDOW_LEN, 48'd5);
        write_reg(lcks_pkg::CFG_TARE_OFFSET, 48'd0);
        write_reg(lcks_pkg::CFG_GRAMS_PER_COUNT, 48'd0);
        write_reg(lcks_pkg::CFG_MEASURE_NOISE, 48'hFFFF_FFFF);
        sample_q.push_back(24'sd42);
        sample_q.push_back(24'sd43);
        drain();

        // random phases across settings; receiver idles heavily first
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin
                send_idle_pct = 61;
                recv_idle_pct = 8;
            end else if (ph == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(lcks_pkg::CFG_WINDOW_LEN, 48'($urandom_range(17)));
            write_reg(lcks_pkg::CFG_TARE_OFFSET, 48'($urandom));
            write_reg(lcks_pkg::CFG_GRAMS_PER_COUNT, ph == 5 ? 48'hFFFF_FFFF_FFFF
                      : {$urandom_range(3) == 0 ? 16'($urandom) : 16'd0, 32'($urandom)});
            write_reg(lcks_pkg::CFG_PROCESS_NOISE,
                      ph == 3 ? 48'hFFFF_FFFF : 48'($urandom_range(1 << 22)));
            write_reg(lcks_pkg::CFG_MEASURE_NOISE, 48'($urandom_range(1 << 22, 1)));
            hold_recv = (ph == 1);
            push_random(200);
            drain();
            hold_recv = 1'b0;
        end

        if (errors == 0) begin
            $display("tb_load_cell_average_kalman_scale OK");
        end else begin
            $display("tb_load_cell_average_kalman_scale NOT OK");
        end
        $finish;
    end

endmodule

@@ load_cell_average_kalman_scale.f @@
design/lcks_pkg.sv
design/lcks_div.sv
design/load_cell_average_kalman_scale.sv
design/lcks_checker.sv
bench/tb_load_cell_average_kalman_scale.sv
